// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file prd_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is active.
`define PRD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, masked while reset is active.
`define PRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

// Next-cycle implication that is also checked during reset.
`define PRD_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication under reset");

`endif

// ----- sv/prd_pkg.sv -----
// Shared types, constants and functions of the phase residue detector.
`default_nettype none

package prd_pkg;

    localparam int MAX_COLS   = 4096;
    localparam int MAX_ROWS   = 4096;
    localparam int PHASE_BITS = 16;
    localparam int CFG_W      = 13;
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int SUM_W      = PHASE_BITS + 2;
    localparam int FILL_W     = COL_W + 1;

    typedef logic [PHASE_BITS-1:0] t_phase;
    typedef logic [CFG_W-1:0]      t_size;
    typedef logic [COL_W-1:0]      t_col;
    typedef logic [ROW_W-1:0]      t_row;
    typedef logic signed [SUM_W-1:0] t_sum;
    typedef logic [1:0]            t_class;
    typedef logic                  t_reg_idx;

    localparam t_class CLASS_NONE   = 2'd0;
    localparam t_class CLASS_POS    = 2'd1;
    localparam t_class CLASS_NEG    = 2'd2;
    localparam t_class CLASS_BORDER = 2'd3;

    localparam t_reg_idx REG_IMAGE_COLS = 1'b0;
    localparam t_reg_idx REG_IMAGE_ROWS = 1'b1;

    localparam t_size SIZE_MIN   = t_size'(4);
    localparam t_size COLS_MAX   = t_size'(MAX_COLS);
    localparam t_size ROWS_MAX   = t_size'(MAX_ROWS);
    localparam t_size COLS_RESET = t_size'(1024);
    localparam t_size ROWS_RESET = t_size'(1024);

    typedef struct packed {
        logic   valid;
        t_col   addr;
        t_phase data;
    } t_lb_wr;

    function automatic t_size sat_size(input t_size v, input t_size hi);
        t_size r;
        r = v;
        if (r < SIZE_MIN) r = SIZE_MIN;
        if (r > hi) r = hi;
        return r;
    endfunction

    // modular difference read as two's complement
    function automatic t_sum wrap_diff(input t_phase a, input t_phase b);
        logic signed [PHASE_BITS-1:0] d;
        d = signed'(a - b);
        return t_sum'(d);
    endfunction

endpackage

`default_nettype wire

// ----- sv/prd_line_buf.sv -----
// Row line buffer: synchronous RAM with fill tracking and write-to-read forwarding.
`default_nettype none

module prd_line_buf
    import prd_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_rd_en,
    input  wire t_col   i_rd_addr,
    input  wire t_lb_wr i_wr,
    output t_phase      o_rd_data
);

    t_phase mem [MAX_COLS];

    t_phase              r_rd_q;
    t_phase              r_fwd_data;
    logic                r_fwd;
    logic                r_known;
    logic [FILL_W-1:0]   r_fill;

    // entries are written as a prefix from column 0, so a count marks them
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_wr.valid && ({1'b0, i_wr.addr} == r_fill)) begin
            r_fill <= r_fill + FILL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.valid) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_q <= mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd   <= 1'b0;
            r_known <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd   <= i_wr.valid && (i_wr.addr == i_rd_addr);
            r_known <= {1'b0, i_rd_addr} < r_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_fwd_data <= i_wr.data;
        end
    end

    assign o_rd_data = r_fwd ? r_fwd_data : (r_known ? r_rd_q : '0);

endmodule

`default_nettype wire

// ----- sv/phase_residue_detector.sv -----
// Top level of the streaming Goldstein phase residue detector.
//
//  channel   direction  handshake                 payload
//  input     in         i_in_valid / o_in_stall   i_phase, i_frame_start
//  output    out        o_out_valid / i_out_stall o_pixel_class, o_frame_last
//  config    in         i_cfg_we                  i_cfg_idx, i_cfg_data
//
// One transaction per cycle unless the output stalls.
// Read data registers with stage 1; classify and write-back run when it advances.
// Same-column write/read in adjacent transactions is forwarded inside the buffer.
// Reset needs no clearing pass: unwritten buffer entries read as zero.
// Input stalls only when a result is held in the output register under stall.
`default_nettype none

module phase_residue_detector
    import prd_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire logic [15:0]     i_phase,
    input  wire logic            i_frame_start,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output logic [1:0]           o_pixel_class,
    output logic                 o_frame_last,
    input  wire logic            i_cfg_we,
    input  wire logic            i_cfg_idx,
    input  wire logic [12:0]     i_cfg_data
);

    t_size  r_cols_cfg, r_rows_cfg;
    t_row   r_row;
    t_col   r_col;

    logic   r_s1_valid, r_s1_res, r_s1_border, r_s1_nocheck, r_s1_last;
    t_phase r_s1_cur;
    t_col   r_s1_col;

    t_phase r_left, r_upl;

    logic   r_out_valid, r_out_last;
    t_class r_out_class;

    t_size  cols, rows, c_ext, r_ext;
    t_row   cur_r;
    t_col   cur_c;
    logic   in_acc, b_adv;
    logic   has_res, border, nocheck, last, r_end, c_end;
    t_phase above;
    t_sum   sum;
    t_class cls;
    t_lb_wr lb_wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols_cfg <= COLS_RESET;
            r_rows_cfg <= ROWS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_IMAGE_COLS: r_cols_cfg <= i_cfg_data;
                REG_IMAGE_ROWS: r_rows_cfg <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign cols = sat_size(r_cols_cfg, COLS_MAX);
    assign rows = sat_size(r_rows_cfg, ROWS_MAX);

    assign b_adv      = r_s1_valid && (!r_s1_res || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !b_adv;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_comb begin
        cur_r   = i_frame_start ? '0 : r_row;
        cur_c   = i_frame_start ? '0 : r_col;
        r_ext   = t_size'(cur_r);
        c_ext   = t_size'(cur_c);
        r_end   = (r_ext + t_size'(1)) == rows;
        c_end   = (c_ext + t_size'(1)) == cols;
        has_res = (cur_r != '0) && (cur_c != '0) && (r_ext < rows) && (c_ext < cols);
        border  = (cur_r == t_row'(1)) || (cur_c == t_col'(1));
        nocheck = r_end || c_end;
        last    = r_end && c_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (in_acc) begin
            if ((c_ext + t_size'(1)) >= cols) begin
                r_col <= '0;
                r_row <= ((r_ext + t_size'(1)) >= rows) ? '0 : cur_r + t_row'(1);
            end else begin
                r_col <= cur_c + t_col'(1);
                r_row <= cur_r;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (b_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_res     <= has_res;
            r_s1_border  <= border;
            r_s1_nocheck <= nocheck;
            r_s1_last    <= last;
            r_s1_cur     <= i_phase;
            r_s1_col     <= cur_c;
        end
    end

    assign lb_wr = '{valid: b_adv, addr: r_s1_col, data: r_s1_cur};

    prd_line_buf u_line_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_acc),
        .i_rd_addr (cur_c),
        .i_wr      (lb_wr),
        .o_rd_data (above)
    );

    always_comb begin
        sum = wrap_diff(above, r_upl) + wrap_diff(r_s1_cur, above)
            + wrap_diff(r_left, r_s1_cur) + wrap_diff(r_upl, r_left);
        if (r_s1_border) begin
            cls = CLASS_BORDER;
        end else if (r_s1_nocheck) begin
            cls = CLASS_NONE;
        end else if (sum > 0) begin
            cls = CLASS_POS;
        end else if (sum < 0) begin
            cls = CLASS_NEG;
        end else begin
            cls = CLASS_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_upl  <= '0;
        end else if (b_adv) begin
            r_left <= r_s1_cur;
            r_upl  <= above;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (b_adv && r_s1_res) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_adv && r_s1_res) begin
            r_out_class <= cls;
            r_out_last  <= r_s1_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_class = r_out_class;
    assign o_frame_last  = r_out_last;

endmodule

`default_nettype wire

// ----- sv/prd_checker.sv -----
// Port-level checker for the phase residue detector, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module prd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_in_stall,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [1:0]  o_pixel_class,
    input wire logic        o_frame_last
);

    `PRD_ASSERT_NEXT(a_out_valid_holds, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)
    `PRD_ASSERT_NEXT(a_out_data_holds, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_pixel_class) && $stable(o_frame_last))
    `PRD_ASSERT_NOW(a_in_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall)
    `PRD_ASSERT_NEXT_ALWAYS(a_reset_clears, i_clk, !i_rst_n, !o_out_valid && !o_in_stall)

endmodule

bind phase_residue_detector prd_checker u_prd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_pixel_class (o_pixel_class),
    .o_frame_last  (o_frame_last)
);

`default_nettype wire
